/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files of this project.
// Each macro takes a label, a clock, a reset, and the property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle property failed");

// Consequent in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle property failed");

`endif

/* rtl/wrrq_pkg.sv */
// Package of the weighted round-robin run queue: codes, state and record types.
// Used by the top level and the port checker; depends on nothing.
package wrrq_pkg;

   // Operation carried in the request tuser.
   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_TICK    = 2'd2,
      OP_YIELD   = 2'd3
   } op_type;

   // Status carried in the response tuser.
   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_QUEUED   = 2'd1,
      ERR_UNQUEUED = 2'd2
   } err_type;

   // Register index taken from the word address.
   typedef enum logic {
      REG_FG_SLICE = 1'b0,
      REG_BG_SLICE = 1'b1
   } csr_reg_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_WRITE1,
      ST_WRITE2,
      ST_PUSH
   } state_type;

   // Per-task record held in the task memory.
   typedef struct packed {
      logic        in_queue;
      logic        class_known;
      logic        is_background;
      logic [15:0] slice;
   } task_rec_type;

   localparam int unsigned FG_WEIGHT = 10;
   localparam int unsigned BG_WEIGHT = 1;

   localparam logic [15:0] FG_SLICE_RESET = 16'd100;
   localparam logic [15:0] BG_SLICE_RESET = 16'd10;

endpackage

/* rtl/wrrq_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module wrrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/weighted_round_robin_run_queue_top.sv */
// Weighted round-robin run queue. Each request item names an operation (enqueue at head or
// tail, dequeue, tick, yield) on one task, and each yields exactly one response item that
// reports the head task, the queue count, the weight sum, the reschedule flag, the addressed
// task's slice and an error code. The task records and the next and previous links live in
// three one-read one-write memories. An item is accepted only in the idle state; its task
// record and links are read in the accept cycle, the execute cycle updates the record and
// makes the first link writes, and because each link memory has one write port, an enqueue
// into a non-empty queue goes on to state WRITE1, and a move to the tail to WRITE1 and, when
// the task is not at the head, WRITE2 as well. An enqueue into an empty queue, a dequeue, a
// tick or yield without a move and an error need no further write state. The response is
// then loaded, or held back in PUSH while the previous response is still held. After reset
// a clearing pass over all MAX_TASKS entries zeroes the task memory before the first item is
// accepted; configuration writes are taken throughout.
// Depends on wrrq_pkg and wrrq_ram.
module weighted_round_robin_run_queue_top #(
   parameter int MAX_TASKS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // task_id[5:0], background[6], to_head[7]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // head_task[5:0], queue_empty[6], queued_count[13:7], weight_sum[23:14],
   // resched[24], slice_left[40:25], zero fill[47:41]
   output logic [47:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // error[1:0]
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IDW = $clog2(MAX_TASKS);
   localparam int CW  = $clog2(MAX_TASKS + 1);
   localparam int WW  = $clog2(wrrq_pkg::FG_WEIGHT * MAX_TASKS + 1);
   localparam int RW  = $bits(wrrq_pkg::task_rec_type);

   typedef struct packed {
      logic           en;
      logic [IDW-1:0] addr;
      logic [IDW-1:0] data;
   } link_wr_type;

   // Sequencer and queue registers.
   wrrq_pkg::state_type state_ff, state_in;
   logic [IDW-1:0]      clear_addr_ff;
   logic [IDW-1:0]      head_ff, head_in;
   logic [IDW-1:0]      tail_ff, tail_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [WW-1:0]       weight_ff, weight_in;
   logic [15:0]         fg_slice_ff, bg_slice_ff;

   // Latched request fields.
   wrrq_pkg::op_type    op_ff;
   logic [IDW-1:0]      task_ff;
   logic                id_ok_ff;
   logic                bg_ff;
   logic                to_head_ff;

   // Pending link writes for the later cycles.
   link_wr_type         nw1_ff, nw2_ff, pw1_ff;
   link_wr_type         nw0, nw1, nw2, pw0, pw1;

   // Result registers.
   logic [47:0]         result_ff, result_in;
   logic [1:0]          result_err_ff;
   logic                rsp_valid_ff;
   logic [47:0]         rsp_data_ff;
   logic [1:0]          rsp_user_ff;

   // Memory ports.
   logic                req_accept;
   logic [IDW-1:0]      req_index;
   logic                task_we;
   logic [IDW-1:0]      task_wa;
   logic [RW-1:0]       task_wd;
   logic [RW-1:0]       task_rd;
   link_wr_type         next_wr, prev_wr;
   logic [IDW-1:0]      next_rd, prev_rd;

   // Execute-cycle signals.
   wrrq_pkg::task_rec_type rec, rec_new;
   wrrq_pkg::err_type      err;
   logic                   rec_we;
   logic                   resched;
   logic                   move;
   logic                   multi;
   logic [15:0]            slice_dec;
   logic [15:0]            slice_out;
   logic [WW-1:0]          task_weight;
   logic                   out_free;
   logic                   rsp_load;
   logic                   csr_write;

   assign req_tready = (state_ff == wrrq_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_index  = IDW'(req_tdata[5:0]);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_slice_ff <= wrrq_pkg::FG_SLICE_RESET;
         bg_slice_ff <= wrrq_pkg::BG_SLICE_RESET;
      end else if (csr_write) begin
         unique case (wrrq_pkg::csr_reg_type'(csr_paddr[2]))
            wrrq_pkg::REG_FG_SLICE: fg_slice_ff <= csr_pwdata[15:0];
            wrrq_pkg::REG_BG_SLICE: bg_slice_ff <= csr_pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      unique case (wrrq_pkg::csr_reg_type'(csr_paddr[2]))
         wrrq_pkg::REG_FG_SLICE: csr_prdata = {16'd0, fg_slice_ff};
         wrrq_pkg::REG_BG_SLICE: csr_prdata = {16'd0, bg_slice_ff};
      endcase
   end

   // Task records, next links and previous links.
   wrrq_ram #(.WIDTH(RW), .DEPTH(MAX_TASKS)) u_task_ram (
      .clock   (clock),
      .wr_en   (task_we),
      .wr_addr (task_wa),
      .wr_data (task_wd),
      .rd_en   (req_accept),
      .rd_addr (req_index),
      .rd_data (task_rd)
   );

   wrrq_ram #(.WIDTH(IDW), .DEPTH(MAX_TASKS)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_wr.en),
      .wr_addr (next_wr.addr),
      .wr_data (next_wr.data),
      .rd_en   (req_accept),
      .rd_addr (req_index),
      .rd_data (next_rd)
   );

   wrrq_ram #(.WIDTH(IDW), .DEPTH(MAX_TASKS)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_wr.en),
      .wr_addr (prev_wr.addr),
      .wr_data (prev_wr.data),
      .rd_en   (req_accept),
      .rd_addr (req_index),
      .rd_data (prev_rd)
   );

   // Latch the request fields when the item is accepted.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff      <= wrrq_pkg::op_type'(req_tuser);
         task_ff    <= req_index;
         id_ok_ff   <= (32'(req_tdata[5:0]) < MAX_TASKS);
         bg_ff      <= req_tdata[6];
         to_head_ff <= req_tdata[7];
      end
   end

   // Execute: decide the record update, queue update and link writes.
   assign rec         = wrrq_pkg::task_rec_type'(task_rd);
   assign multi       = (count_ff > CW'(1));
   assign slice_dec   = rec.slice - 16'd1;
   assign task_weight = rec_new.is_background ? WW'(wrrq_pkg::BG_WEIGHT)
                                              : WW'(wrrq_pkg::FG_WEIGHT);

   always_comb begin
      err       = wrrq_pkg::ERR_NONE;
      rec_we    = 1'b0;
      rec_new   = rec;
      resched   = 1'b0;
      move      = 1'b0;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      weight_in = weight_ff;
      nw0       = '0;
      nw1       = '0;
      nw2       = '0;
      pw0       = '0;
      pw1       = '0;

      if (!id_ok_ff) begin
         err = wrrq_pkg::ERR_UNQUEUED;
      end else if (op_ff == wrrq_pkg::OP_ENQUEUE) begin
         if (rec.in_queue) begin
            err = wrrq_pkg::ERR_QUEUED;
         end else begin
            // Reload the slice when the class is new or has changed.
            rec_we           = 1'b1;
            rec_new.in_queue = 1'b1;
            if (!rec.class_known || (rec.is_background != bg_ff)) begin
               rec_new.class_known   = 1'b1;
               rec_new.is_background = bg_ff;
               rec_new.slice         = bg_ff ? bg_slice_ff : fg_slice_ff;
            end
            count_in  = count_ff + CW'(1);
            weight_in = weight_ff + task_weight;
            if (count_ff == '0) begin
               head_in = task_ff;
               tail_in = task_ff;
               nw0     = '{1'b1, task_ff, task_ff};
               pw0     = '{1'b1, task_ff, task_ff};
            end else if (to_head_ff) begin
               nw0     = '{1'b1, task_ff, head_ff};
               pw0     = '{1'b1, task_ff, task_ff};
               pw1     = '{1'b1, head_ff, task_ff};
               head_in = task_ff;
            end else begin
               pw0     = '{1'b1, task_ff, tail_ff};
               nw0     = '{1'b1, task_ff, task_ff};
               nw1     = '{1'b1, tail_ff, task_ff};
               tail_in = task_ff;
            end
         end
      end else if (!rec.in_queue) begin
         err = wrrq_pkg::ERR_UNQUEUED;
      end else begin
         unique case (op_ff)
            wrrq_pkg::OP_ENQUEUE: begin
            end
            wrrq_pkg::OP_DEQUEUE: begin
               // Unlink from anywhere in the queue.
               rec_we           = 1'b1;
               rec_new.in_queue = 1'b0;
               count_in         = count_ff - CW'(1);
               weight_in        = weight_ff - task_weight;
               if (task_ff == head_ff) begin
                  head_in = next_rd;
               end else begin
                  nw0 = '{1'b1, prev_rd, next_rd};
               end
               if (task_ff == tail_ff) begin
                  tail_in = prev_rd;
               end else begin
                  pw0 = '{1'b1, next_rd, prev_rd};
               end
            end
            wrrq_pkg::OP_TICK: begin
               // Count down; on expiry reload and move to the tail if others wait.
               rec_we = 1'b1;
               if (slice_dec == 16'd0) begin
                  rec_new.slice = rec.is_background ? bg_slice_ff : fg_slice_ff;
                  resched       = multi;
                  move          = multi && (task_ff != tail_ff);
               end else begin
                  rec_new.slice = slice_dec;
               end
            end
            wrrq_pkg::OP_YIELD: begin
               move = multi && (task_ff != tail_ff);
            end
         endcase
      end

      // Move to the tail: unlink, then link behind the old tail.
      if (move) begin
         if (task_ff == head_ff) begin
            head_in = next_rd;
         end else begin
            nw2 = '{1'b1, prev_rd, next_rd};
         end
         pw0     = '{1'b1, next_rd, prev_rd};
         nw0     = '{1'b1, tail_ff, task_ff};
         nw1     = '{1'b1, task_ff, task_ff};
         pw1     = '{1'b1, task_ff, tail_ff};
         tail_in = task_ff;
      end
   end

   // Result of the step.
   assign slice_out = (id_ok_ff && rec_new.class_known) ? rec_new.slice : 16'd0;
   assign result_in = {7'd0, slice_out, resched, 10'(weight_in), 7'(count_in),
                       (count_in == '0), (count_in != '0) ? 6'(head_in) : 6'd0};

   // Memory write port selection.
   always_comb begin
      task_we = 1'b0;
      task_wa = task_ff;
      task_wd = rec_new;
      next_wr = '0;
      prev_wr = '0;
      unique case (state_ff)
         wrrq_pkg::ST_CLEAR: begin
            task_we = 1'b1;
            task_wa = clear_addr_ff;
            task_wd = '0;
         end
         wrrq_pkg::ST_EXEC: begin
            task_we = rec_we;
            next_wr = nw0;
            prev_wr = pw0;
         end
         wrrq_pkg::ST_WRITE1: begin
            next_wr = nw1_ff;
            prev_wr = pw1_ff;
         end
         wrrq_pkg::ST_WRITE2: begin
            next_wr = nw2_ff;
         end
         wrrq_pkg::ST_IDLE, wrrq_pkg::ST_PUSH: begin
         end
         default: begin
         end
      endcase
   end

   // Sequencer next state and response load.
   always_comb begin
      state_in = state_ff;
      rsp_load = 1'b0;
      unique case (state_ff)
         wrrq_pkg::ST_CLEAR: begin
            if (clear_addr_ff == IDW'(MAX_TASKS - 1)) begin
               state_in = wrrq_pkg::ST_IDLE;
            end
         end
         wrrq_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = wrrq_pkg::ST_EXEC;
            end
         end
         wrrq_pkg::ST_EXEC: begin
            if (nw1.en || pw1.en) begin
               state_in = wrrq_pkg::ST_WRITE1;
            end else begin
               rsp_load = out_free;
               state_in = out_free ? wrrq_pkg::ST_IDLE : wrrq_pkg::ST_PUSH;
            end
         end
         wrrq_pkg::ST_WRITE1: begin
            if (nw2_ff.en) begin
               state_in = wrrq_pkg::ST_WRITE2;
            end else begin
               rsp_load = out_free;
               state_in = out_free ? wrrq_pkg::ST_IDLE : wrrq_pkg::ST_PUSH;
            end
         end
         wrrq_pkg::ST_WRITE2, wrrq_pkg::ST_PUSH: begin
            rsp_load = out_free;
            state_in = out_free ? wrrq_pkg::ST_IDLE : wrrq_pkg::ST_PUSH;
         end
         default: begin
            state_in = wrrq_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= wrrq_pkg::ST_CLEAR;
         clear_addr_ff <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         weight_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == wrrq_pkg::ST_CLEAR) begin
            clear_addr_ff <= clear_addr_ff + IDW'(1);
         end
         if (state_ff == wrrq_pkg::ST_EXEC) begin
            head_ff   <= head_in;
            tail_ff   <= tail_in;
            count_ff  <= count_in;
            weight_ff <= weight_in;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Pending writes, held result and response payload.
   always_ff @(posedge clock) begin
      if (state_ff == wrrq_pkg::ST_EXEC) begin
         nw1_ff        <= nw1;
         nw2_ff        <= nw2;
         pw1_ff        <= pw1;
         result_ff     <= result_in;
         result_err_ff <= err;
      end
      if (rsp_load) begin
         if (state_ff == wrrq_pkg::ST_EXEC) begin
            rsp_data_ff <= result_in;
            rsp_user_ff <= err;
         end else begin
            rsp_data_ff <= result_ff;
            rsp_user_ff <= result_err_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* rtl/wrrq_checker.sv */
// Port-level checker of the weighted round-robin run queue, bound to the top level.
// Depends on wrrq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wrrq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // A stalled response item holds its payload.
   `ASSERT_NEXT_CYCLE(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // An empty queue reports no tasks, no weight and head task zero.
   `ASSERT_SAME_CYCLE(a_empty_fields, clock, reset, rsp_tvalid && rsp_tdata[6], (rsp_tdata[13:7] == 7'd0) && (rsp_tdata[23:14] == 10'd0) && (rsp_tdata[5:0] == 6'd0))

   // A reschedule is only flagged by a successful step on a queue of two or more.
   `ASSERT_SAME_CYCLE(a_resched_ok, clock, reset, rsp_tvalid && rsp_tdata[24], (rsp_tuser == wrrq_pkg::ERR_NONE) && !rsp_tdata[6] && (rsp_tdata[13:7] != 7'd1))

   // The error field never carries the unused code.
   `ASSERT_SAME_CYCLE(a_err_code, clock, reset, rsp_tvalid, (rsp_tuser == wrrq_pkg::ERR_NONE) || (rsp_tuser == wrrq_pkg::ERR_QUEUED) || (rsp_tuser == wrrq_pkg::ERR_UNQUEUED))

endmodule

bind weighted_round_robin_run_queue_top wrrq_checker u_wrrq_checker (.*);

/* dv/tb.sv */
// Self-checking testbench for the weighted round-robin run queue top level.
// Holds a run-queue predictor and checker class, then the tb module that drives the
// request, response and register ports. Depends on wrrq_pkg and the RTL only.

// One response item as it is compared, field by field.
typedef struct packed {
   logic [5:0]        head_task;
   logic              queue_empty;
   logic [6:0]        queued_count;
   logic [9:0]        weight_sum;
   logic              resched;
   logic [15:0]       slice_left;
   wrrq_pkg::err_type error;
} run_status_type;

// Predicts the queue state after every accepted request item and checks responses in order.
class run_queue_predictor;
   logic [15:0] fg_reload;
   logic [15:0] bg_reload;
   logic [5:0]  next_task [64];
   logic [5:0]  prev_task [64];
   logic [15:0] slice_ticks [64];
   bit          is_bg [64];
   bit          known [64];
   bit          queued [64];
   logic [5:0]  head;
   logic [5:0]  tail;
   int unsigned count;
   int unsigned weight;
   run_status_type expected_status [$];
   int unsigned errors;
   int unsigned checked;

   function new();
      fg_reload = wrrq_pkg::FG_SLICE_RESET;
      bg_reload = wrrq_pkg::BG_SLICE_RESET;
      foreach (queued[i]) begin
         is_bg[i] = 1'b0;
         known[i] = 1'b0;
         queued[i] = 1'b0;
      end
      head = '0;
      tail = '0;
      count = 0;
      weight = 0;
      errors = 0;
      checked = 0;
   endfunction

   function void set_reload(wrrq_pkg::csr_reg_type which, logic [15:0] value);
      if (which == wrrq_pkg::REG_FG_SLICE) begin
         fg_reload = value;
      end else begin
         bg_reload = value;
      end
   endfunction

   function logic [15:0] reload_of(wrrq_pkg::csr_reg_type which);
      return (which == wrrq_pkg::REG_FG_SLICE) ? fg_reload : bg_reload;
   endfunction

   function int unsigned weight_of(logic [5:0] t);
      return is_bg[t] ? wrrq_pkg::BG_WEIGHT : wrrq_pkg::FG_WEIGHT;
   endfunction

   // Link insertion; a task at either end points at itself on the open side.
   function void link_task(logic [5:0] t, bit at_head);
      if (count == 0) begin
         head = t;
         tail = t;
         next_task[t] = t;
         prev_task[t] = t;
      end else if (at_head) begin
         next_task[t] = head;
         prev_task[t] = t;
         prev_task[head] = t;
         head = t;
      end else begin
         prev_task[t] = tail;
         next_task[t] = t;
         next_task[tail] = t;
         tail = t;
      end
      count++;
   endfunction

   function void unlink_task(logic [5:0] t);
      logic [5:0] n;
      logic [5:0] p;
      n = next_task[t];
      p = prev_task[t];
      if (t == head) begin
         head = n;
      end else begin
         next_task[p] = n;
      end
      if (t == tail) begin
         tail = p;
      end else begin
         prev_task[n] = p;
      end
      count--;
   endfunction

   function void send_to_tail(logic [5:0] t);
      if (count > 1 && t != tail) begin
         unlink_task(t);
         link_task(t, 1'b0);
      end
   endfunction

   // Applies one accepted request item and queues the response it must produce.
   function void note_request(wrrq_pkg::op_type op, logic [5:0] t, bit bg, bit at_head);
      run_status_type want;
      want = '0;
      want.error = wrrq_pkg::ERR_NONE;
      if (op == wrrq_pkg::OP_ENQUEUE) begin
         if (queued[t]) begin
            want.error = wrrq_pkg::ERR_QUEUED;
         end else begin
            // A new or changed class reloads the slice from its register.
            if (!known[t] || is_bg[t] != bg) begin
               is_bg[t] = bg;
               known[t] = 1'b1;
               slice_ticks[t] = bg ? bg_reload : fg_reload;
            end
            link_task(t, at_head);
            queued[t] = 1'b1;
            weight += weight_of(t);
         end
      end else if (!queued[t]) begin
         want.error = wrrq_pkg::ERR_UNQUEUED;
      end else if (op == wrrq_pkg::OP_DEQUEUE) begin
         unlink_task(t);
         queued[t] = 1'b0;
         weight -= weight_of(t);
      end else if (op == wrrq_pkg::OP_TICK) begin
         // A zero slice wraps round and does not expire.
         slice_ticks[t] = slice_ticks[t] - 16'd1;
         if (slice_ticks[t] == 16'd0) begin
            slice_ticks[t] = is_bg[t] ? bg_reload : fg_reload;
            if (count > 1) begin
               send_to_tail(t);
               want.resched = 1'b1;
            end
         end
      end else begin
         send_to_tail(t);
      end
      if (known[t]) begin
         want.slice_left = slice_ticks[t];
      end
      want.head_task = (count != 0) ? head : 6'd0;
      want.queue_empty = (count == 0);
      want.queued_count = count[6:0];
      want.weight_sum = weight[9:0];
      expected_status.push_back(want);
   endfunction

   // Prints one line per mismatch and counts it.
   task report(string msg);
      errors++;
      $display("MISMATCH at response %0d: %s", checked, msg);
   endtask

   task compare_field(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
         report($sformatf("%s expected %0d, got %0d", name, want, seen));
      end
   endtask

   task check_status(logic [47:0] data, logic [1:0] user);
      run_status_type want;
      checked++;
      if (expected_status.size() == 0) begin
         report("response item with nothing expected");
      end else begin
         want = expected_status.pop_front();
         compare_field("head_task", want.head_task, data[5:0]);
         compare_field("queue_empty", want.queue_empty, data[6]);
         compare_field("queued_count", want.queued_count, data[13:7]);
         compare_field("weight_sum", want.weight_sum, data[23:14]);
         compare_field("resched", want.resched, data[24]);
         compare_field("slice_left", want.slice_left, data[40:25]);
         compare_field("error", want.error, user);
      end
   endtask
endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // task_id[5:0], background[6], to_head[7]
   logic [1:0]  req_tuser = '0;    // operation[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // head_task[5:0], queue_empty[6], queued_count[13:7], weight_sum[23:14],
   // resched[24], slice_left[40:25], zero fill[47:41]
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;         // error[1:0]
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   run_queue_predictor sb = new();
   int gap_pct = 0;
   int stall_left = 0;
   int cycle_count = 0;

   weighted_round_robin_run_queue_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Response back-pressure in random bursts while idling is enabled.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct / 2) begin
         stall_left <= $urandom_range(0, 8);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Every accepted response item is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_status(rsp_tdata, rsp_tuser);
      end
   end

   // Sends one request item; entered and left at a falling edge.
   task automatic send_request(wrrq_pkg::op_type op, logic [5:0] id, bit bg, bit at_head);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {at_head, bg, id};
      req_tuser <= op;
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, id, bg, at_head);
      @(negedge clock);
   endtask

   // Waits until every expected response has arrived, then lets the block settle.
   task automatic await_idle();
      req_tvalid <= 1'b0;
      while (sb.expected_status.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Writes a slice register, then reads it back.
   task automatic set_register(wrrq_pkg::csr_reg_type which, logic [15:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {which, 2'b00};
      csr_pwdata <= {16'h0000, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_reload(which, value);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {16'h0000, sb.reload_of(which)}) begin
         sb.report($sformatf("register %0d read %0h, expected %0h", which, csr_prdata,
                             sb.reload_of(which)));
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly well-formed operations on tasks chosen from the queue state, with some noise.
   task automatic pick_request(int window, int enq_pct, output wrrq_pkg::op_type op,
                               output logic [5:0] id, output bit bg, output bit at_head);
      int unsigned roll;
      logic [5:0] waiting [$];
      logic [5:0] free_ids [$];
      for (int i = 0; i < 64; i++) begin
         if (sb.queued[i]) begin
            waiting.push_back(6'(i));
         end else if (i < window) begin
            free_ids.push_back(6'(i));
         end
      end
      roll = $urandom_range(0, 99);
      bg = 1'($urandom_range(0, 1));
      at_head = ($urandom_range(0, 3) == 0);
      if (roll < 8) begin
         op = wrrq_pkg::op_type'($urandom_range(0, 3));
         id = 6'($urandom_range(0, 63));
      end else if (waiting.size() == 0 || (roll < 8 + enq_pct && free_ids.size() != 0)) begin
         op = wrrq_pkg::OP_ENQUEUE;
         id = free_ids[$urandom_range(0, free_ids.size() - 1)];
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 20) begin
            op = wrrq_pkg::OP_DEQUEUE;
         end else if (roll < 80) begin
            op = wrrq_pkg::OP_TICK;
         end else begin
            op = wrrq_pkg::OP_YIELD;
         end
         id = waiting[$urandom_range(0, waiting.size() - 1)];
         // The running task is normally the one at the head.
         if (op == wrrq_pkg::OP_TICK && $urandom_range(0, 3) != 0) begin
            id = sb.head;
         end
      end
   endtask

   task automatic run_phase(logic [15:0] fg, logic [15:0] bg, int window, int enq_pct,
                            int items, int gaps);
      wrrq_pkg::op_type op;
      logic [5:0] id;
      bit is_bg;
      bit at_head;
      await_idle();
      set_register(wrrq_pkg::REG_FG_SLICE, fg);
      set_register(wrrq_pkg::REG_BG_SLICE, bg);
      gap_pct = gaps;
      repeat (items) begin
         pick_request(window, enq_pct, op, id, is_bg, at_head);
         send_request(op, id, is_bg, at_head);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      gap_pct = 30;

      // Short slices so that expiry is reached within a few ticks.
      set_register(wrrq_pkg::REG_FG_SLICE, 16'd2);
      set_register(wrrq_pkg::REG_BG_SLICE, 16'd1);

      // Operations on a task that is not queued, and on an empty queue.
      send_request(wrrq_pkg::OP_TICK, 6'd5, 1'b0, 1'b0);
      send_request(wrrq_pkg::OP_YIELD, 6'd5, 1'b1, 1'b1);
      send_request(wrrq_pkg::OP_DEQUEUE, 6'd5, 1'b0, 1'b0);
      // Both ends of the id range, both classes, both insert positions, double enqueue.
      send_request(wrrq_pkg::OP_ENQUEUE, 6'd0, 1'b0, 1'b0);
      send_request(wrrq_pkg::OP_ENQUEUE, 6'd63, 1'b1, 1'b1);
      send_request(wrrq_pkg::OP_ENQUEUE, 6'd0, 1'b0, 1'b1);
      // Expiry with a move to the tail, from the head each time.
      send_request(wrrq_pkg::OP_TICK, 6'd63, 1'b0, 1'b0);
      send_request(wrrq_pkg::OP_TICK, 6'd0, 1'b0, 1'b0);
      send_request(wrrq_pkg::OP_TICK, 6'd0, 1'b0, 1'b0);
      // Yield of the tail task stays put; yield of the head moves it.
      send_request(wrrq_pkg::OP_ENQUEUE, 6'd1, 1'b0, 1'b0);
      send_request(wrrq_pkg::OP_YIELD, 6'd1, 1'b0, 1'b0);
      send_request(wrrq_pkg::OP_YIELD, 6'd63, 1'b0, 1'b0);
      // Dequeue from the middle and from the head, then expiry of a lone task.
      send_request(wrrq_pkg::OP_DEQUEUE, 6'd1, 1'b0, 1'b0);
      send_request(wrrq_pkg::OP_DEQUEUE, 6'd0, 1'b0, 1'b0);
      send_request(wrrq_pkg::OP_TICK, 6'd63, 1'b0, 1'b0);
      send_request(wrrq_pkg::OP_DEQUEUE, 6'd63, 1'b0, 1'b0);
      // A class change reloads the slice; the same class keeps it.
      send_request(wrrq_pkg::OP_ENQUEUE, 6'd0, 1'b1, 1'b1);
      send_request(wrrq_pkg::OP_DEQUEUE, 6'd0, 1'b0, 1'b0);
      send_request(wrrq_pkg::OP_ENQUEUE, 6'd0, 1'b1, 1'b0);

      // A zero slice register: the reload gives zero and a tick wraps it.
      await_idle();
      set_register(wrrq_pkg::REG_FG_SLICE, 16'd0);
      send_request(wrrq_pkg::OP_ENQUEUE, 6'd2, 1'b0, 1'b1);
      send_request(wrrq_pkg::OP_TICK, 6'd2, 1'b0, 1'b0);
      send_request(wrrq_pkg::OP_YIELD, 6'd2, 1'b0, 1'b0);
      send_request(wrrq_pkg::OP_DEQUEUE, 6'd2, 1'b0, 1'b0);
      send_request(wrrq_pkg::OP_DEQUEUE, 6'd0, 1'b0, 1'b0);

      // Random phases over several register settings, the extremes among them.
      run_phase(16'd3, 16'd1, 8, 45, 300, 30);
      run_phase(16'd65535, 16'd65535, 64, 70, 250, 30);
      run_phase(16'd1, 16'd2, 16, 40, 300, 20);
      run_phase(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)), 64, 30, 300, 40);
      run_phase(16'd5, 16'd65535, 4, 35, 250, 30);
      run_phase(16'd2, 16'd3, 32, 50, 250, 0);

      await_idle();
      if (sb.errors == 0 && sb.expected_status.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

/* filelist.f */
+incdir+rtl
rtl/wrrq_pkg.sv
rtl/wrrq_ram.sv
rtl/weighted_round_robin_run_queue_top.sv
rtl/wrrq_checker.sv
dv/tb.sv
